FILE: hw/rtl/pbo_pkg.sv
// Shared package for the PolyBLEP oscillator: register indexes, waveform codes,
// widths, sequencer states and the request/response structs of the divider.
// Depends on nothing; every other file of the block imports it.
package pbo_pkg;

  // Default parameter values
  localparam int PHASE_BITS_DEF = 32;
  localparam int SINE_DEPTH_DEF = 256;

  // Register and field widths
  localparam int WAVE_W    = 3;
  localparam int STEP_W    = 31;
  localparam int CFG_IDX_W = 1;
  localparam int SAMPLE_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SELECT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 1'd1;

  // Waveform codes; the remaining codes are silent
  localparam logic [WAVE_W-1:0] WAVE_SAW    = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_SINE   = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_TRI    = 3'd3;

  // Fixed-point layout: Q1.30 working values, 30 quotient bits, two per step
  localparam int QUO_W     = 30;
  localparam int DIV_STEPS = QUO_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int SINE_W    = 31;
  localparam int ACC_W     = 34;

  // Start request to the shared divider
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  // Completion from the shared divider
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  // Sequencer states
  typedef enum logic [8:0] {
    S_IDLE     = 9'b0_0000_0001,
    S_SETUP    = 9'b0_0000_0010,
    S_BLEP     = 9'b0_0000_0100,
    S_DIV      = 9'b0_0000_1000,
    S_RSQ      = 9'b0_0001_0000,
    S_ACC      = 9'b0_0010_0000,
    S_SIN_ADDR = 9'b0_0100_0000,
    S_SIN_DATA = 9'b0_1000_0000,
    S_OUT      = 9'b1_0000_0000
  } state_t;

endpackage

FILE: hw/rtl/pbo_divider.sv
// Iterative restoring divider giving floor(num * 2^30 / den) for num < den,
// two quotient bits per cycle. Depends on pbo_pkg.
module pbo_divider
  import pbo_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [31:0]          rem_r;
  logic [31:0]          den_r;
  logic [QUO_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [32:0] r1, r1s, r2, r2s;
  logic        ge1, ge2;

  // Two cascaded compare-and-subtract steps
  always_comb begin
    r1  = {rem_r, 1'b0};
    ge1 = r1 >= {1'b0, den_r};
    r1s = ge1 ? r1 - {1'b0, den_r} : r1;
    r2  = {r1s[31:0], 1'b0};
    ge2 = r2 >= {1'b0, den_r};
    r2s = ge2 ? r2 - {1'b0, den_r} : r2;
  end

  // Step counter and completion flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient
  always_ff @(posedge clk) begin
    if (req_i.start) begin
      rem_r <= req_i.num;
      den_r <= req_i.den;
    end else if (busy_r) begin
      rem_r <= r2s[31:0];
      quo_r <= {quo_r[QUO_W-3:0], ge1, ge2};
    end
  end

  assign rsp_o.done = done_r;
  assign rsp_o.quo  = quo_r;

endmodule

FILE: hw/rtl/pbo_sine_rom.sv
// Quarter-wave sine table, entries 0 to DEPTH as Q1.30, with a registered read.
// The contents are worked out at elaboration from a fixed-point Taylor series.
// Depends on pbo_pkg.
module pbo_sine_rom
  import pbo_pkg::*;
#(
  parameter int DEPTH  = SINE_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr_i,
  output logic [SINE_W-1:0] data_o
);

  typedef logic [SINE_W-1:0] rom_t [DEPTH+1];

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          ONE_Q30     = 64'd1073741824;

  // sin(pi/2 * j / DEPTH) by a seven-term series (entry DEPTH set to 1), clamped to [0, 1]
  function automatic rom_t build_rom();
    rom_t            rom;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint          sum;
    for (int j = 0; j <= DEPTH; j++) begin
      if (j == DEPTH) begin
        rom[j] = SINE_W'(ONE_Q30);
      end else begin
        a    = (HALF_PI_Q30 * 64'(j)) / DEPTH;
        a2   = (a * a) >> 30;
        term = a;
        sum  = longint'(a);
        for (int n = 1; n <= 6; n++) begin
          term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) sum = sum - longint'(term);
          else            sum = sum + longint'(term);
        end
        if (sum < 0)       sum = 0;
        if (sum > ONE_Q30) sum = ONE_Q30;
        rom[j] = SINE_W'(sum);
      end
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Registered read port
  always_ff @(posedge clk) begin
    data_o <= SINE_ROM[addr_i];
  end

endmodule

FILE: hw/rtl/polyblep_oscillator.sv
// PolyBLEP oscillator top level: triangle and silence go from setup straight to the
// output, sine through a registered table read, saw and square through a correction
// test; a saw takes at most one correction, a square at most two, one per jump of the wave.
// in_tready returns as the result is offered, so one item is taken at a time; each
// correction runs through the shared divider (two bits a cycle, 15 steps).
// rst_n is synchronous: phase, registers and sequencer clear, no clearing pass.
module polyblep_oscillator
  import pbo_pkg::*;
#(
  parameter int PHASE_BITS       = PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input items
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] restart, [7:1] zero
  // Result items
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [SAMPLE_W-1:0]  out_tdata,  // [15:0] sample_out
  // Configuration writes
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [STEP_W-1:0]    cfg_wdata
);

  localparam int PB     = PHASE_BITS;
  localparam int DEPTH  = SINE_TABLE_DEPTH;
  localparam int IDX_W  = $clog2(4 * DEPTH);
  localparam int ADDR_W = $clog2(DEPTH + 1);
  localparam logic signed [ACC_W-1:0] ONE_Q30 = ACC_W'(64'd1073741824);

  // Registers
  logic [WAVE_W-1:0]         wave_sel_r;
  logic [STEP_W-1:0]         phase_step_r;
  logic [PB-1:0]             phase_acc_r;
  state_t                    state_r;
  logic [31:0]               t_r;
  logic [31:0]               dt_r;
  logic [31:0]               p_r;
  logic                      op_neg_r;
  logic                      second_r;
  logic                      blep_after_r;
  logic                      sin_neg_r;
  logic signed [ACC_W-1:0]   s_r;
  logic [63:0]               prod_r;
  logic                      out_tvalid_r;
  logic [SAMPLE_W-1:0]       out_tdata_r;

  logic                      in_acc;
  logic                      out_load;
  logic [PB-1:0]             phase_cur;
  logic [PB-1:0]             step_pb;
  logic [31:0]               t_cur;
  logic [31:0]               dt_cur;

  // Phase and step rescaled to 0.32 fractions
  assign phase_cur = in_tdata[0] ? '0 : phase_acc_r;

  generate
    if (PB >= 32) begin : g_wide
      assign step_pb = PB'(phase_step_r);
      assign t_cur   = phase_cur[PB-1 -: 32];
      assign dt_cur  = step_pb[PB-1 -: 32];
    end else begin : g_narrow
      assign step_pb = phase_step_r[PB-1:0];
      assign t_cur   = {phase_cur, {(32 - PB){1'b0}}};
      assign dt_cur  = {step_pb, {(32 - PB){1'b0}}};
    end
  endgenerate

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_sel_r   <= '0;
      phase_step_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WAVE_SELECT: wave_sel_r   <= cfg_wdata[WAVE_W-1:0];
        CFG_PHASE_STEP:  phase_step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Correction window test for the phase under inspection
  logic [31:0] p_neg;
  logic        win_after;
  logic        win_before;

  assign p_neg      = 32'd0 - p_r;
  assign win_after  = (dt_r != 32'd0) && (p_r < dt_r);
  assign win_before = (dt_r != 32'd0) && !win_after && (p_neg < dt_r);

  // Shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign div_req.start = (state_r == S_BLEP) && (win_after || win_before);
  assign div_req.num   = win_after ? p_r : p_neg;
  assign div_req.den   = dt_r;

  pbo_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Shared multiplier: sine index scaling, or the square of r = 1 - m
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [30:0] r_val;

  assign r_val = 31'h4000_0000 - {1'b0, div_rsp.quo};

  always_comb begin
    if (state_r == S_SETUP) begin
      mul_a = t_r;
      mul_b = 32'(4 * DEPTH);
    end else begin
      mul_a = {1'b0, r_val};
      mul_b = {1'b0, r_val};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Sine table address from the scaled phase
  logic [IDX_W-1:0]  sin_idx;
  logic [1:0]        sin_quad;
  logic [IDX_W-1:0]  sin_k_full;
  logic [ADDR_W-1:0] sin_k;
  logic [ADDR_W-1:0] rom_addr;
  logic [SINE_W-1:0] rom_data;

  assign sin_idx = prod_r[32 +: IDX_W];

  always_comb begin
    if (sin_idx >= IDX_W'(3 * DEPTH)) begin
      sin_quad   = 2'd3;
      sin_k_full = sin_idx - IDX_W'(3 * DEPTH);
    end else if (sin_idx >= IDX_W'(2 * DEPTH)) begin
      sin_quad   = 2'd2;
      sin_k_full = sin_idx - IDX_W'(2 * DEPTH);
    end else if (sin_idx >= IDX_W'(DEPTH)) begin
      sin_quad   = 2'd1;
      sin_k_full = sin_idx - IDX_W'(DEPTH);
    end else begin
      sin_quad   = 2'd0;
      sin_k_full = sin_idx;
    end
    sin_k    = sin_k_full[ADDR_W-1:0];
    rom_addr = sin_quad[0] ? ADDR_W'(DEPTH) - sin_k : sin_k;
  end

  pbo_sine_rom #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_rom (
    .clk    (clk),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // Initial value per waveform, the triangle and the correction sum
  logic signed [ACC_W-1:0] saw_base;
  logic signed [ACC_W-1:0] tri_abs;
  logic signed [ACC_W-1:0] corr;
  logic signed [ACC_W-1:0] s_acc;

  assign saw_base = $signed({2'b00, t_r}) >>> 1;
  assign tri_abs  = ((saw_base - ONE_Q30) < 0) ? (ONE_Q30 - saw_base) : (saw_base - ONE_Q30);
  assign corr     = $signed({3'b000, prod_r[60:30]});
  assign s_acc    = (blep_after_r ^ op_neg_r) ? (s_r - corr) : (s_r + corr);

  // Rounding half up to Q1.15 with saturation
  logic signed [ACC_W-1:0] s_rnd;
  logic signed [ACC_W-1:0] q_full;
  logic [SAMPLE_W-1:0]     q_sat;

  assign s_rnd  = s_r + ACC_W'(1 << 14);
  assign q_full = s_rnd >>> 15;

  always_comb begin
    if (q_full > ACC_W'(32767))                      q_sat = 16'h7FFF;
    else if (q_full < -$signed(ACC_W'(32768)))       q_sat = 16'h8000;
    else                                             q_sat = q_full[SAMPLE_W-1:0];
  end

  // The finished sample moves into the output register once that is free
  assign out_load = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  // Output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_acc_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            phase_acc_r <= phase_cur + step_pb;
            t_r         <= t_cur;
            dt_r        <= dt_cur;
            state_r     <= S_SETUP;
          end
        end
        S_SETUP: begin
          p_r      <= t_r;
          op_neg_r <= (wave_sel_r == WAVE_SAW);
          second_r <= (wave_sel_r == WAVE_SQUARE);
          case (wave_sel_r)
            WAVE_SAW: begin
              s_r      <= saw_base - ONE_Q30;
              state_r  <= S_BLEP;
            end
            WAVE_SQUARE: begin
              s_r      <= t_r[31] ? -ONE_Q30 : ONE_Q30;
              state_r  <= S_BLEP;
            end
            WAVE_SINE: begin
              state_r <= S_SIN_ADDR;
            end
            WAVE_TRI: begin
              s_r     <= (tri_abs <<< 1) - ONE_Q30;
              state_r <= S_OUT;
            end
            default: begin
              s_r     <= '0;
              state_r <= S_OUT;
            end
          endcase
        end
        S_BLEP: begin
          blep_after_r <= win_after;
          if (win_after || win_before) begin
            state_r <= S_DIV;
          end else if (second_r) begin
            p_r      <= t_r + 32'h8000_0000;
            op_neg_r <= 1'b1;
            second_r <= 1'b0;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_rsp.done) state_r <= S_RSQ;
        end
        S_RSQ: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          s_r <= s_acc;
          if (second_r) begin
            p_r      <= t_r + 32'h8000_0000;
            op_neg_r <= 1'b1;
            second_r <= 1'b0;
            state_r  <= S_BLEP;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_SIN_ADDR: begin
          sin_neg_r <= sin_quad[1];
          state_r   <= S_SIN_DATA;
        end
        S_SIN_DATA: begin
          s_r     <= sin_neg_r ? -$signed({3'b000, rom_data}) : $signed({3'b000, rom_data});
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_tdata_r  <= q_sat;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
